@@ design/stm_pkg.sv @@
// Shared types and constants for the stripe target mapper.
`default_nettype none

package stm_pkg;

  // Request codes on the input channel
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_MAP  = 1'b1;

  // Configuration register indexes
  localparam logic [0:0] CFG_CHUNK_LOG2  = 1'b0;
  localparam logic [0:0] CFG_NUM_TARGETS = 1'b1;

  // Field widths
  localparam int POS_W   = 63;
  localparam int EIDX_W  = 6;
  localparam int EID_W   = 16;
  localparam int SHIFT_W = 5;
  localparam int N_W     = 7;
  localparam int CFG_W   = 7;

  // Remainder pipeline: one quotient bit per step, eight steps per stage
  localparam int Q_W         = 64;
  localparam int STEPS_STAGE = 8;
  localparam int MOD_STAGES  = Q_W / STEPS_STAGE;

  // One request as it travels down the pipeline
  typedef struct packed {
    logic              cmd;
    logic [Q_W-1:0]    q;
    logic [N_W-1:0]    rem;
    logic [EIDX_W-1:0] entry_index;
    logic [EID_W-1:0]  entry_id;
  } stm_item_t;

endpackage : stm_pkg

`default_nettype wire

@@ design/stm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module stm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; hold data between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : stm_ram

`default_nettype wire

@@ design/stm_mod_stage.sv @@
// One remainder pipeline stage: eight restoring steps of the quotient modulo the target count.
`default_nettype none

module stm_mod_stage
  import stm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [N_W-1:0]   n,
  input  wire logic             up_valid,
  input  wire stm_item_t        up_item,
  output logic                  up_ready,
  output logic                  valid_r,
  output stm_item_t             item_r,
  input  wire logic             down_ready
);

  stm_item_t item_nxt;

  // Shift in one quotient bit per step, subtract the divisor when it fits
  always_comb begin
    logic [N_W:0]   t;
    logic [N_W-1:0] r;
    logic [Q_W-1:0] q;
    item_nxt = up_item;
    r = up_item.rem;
    q = up_item.q;
    for (int i = 0; i < STEPS_STAGE; i++) begin
      t = {r, q[Q_W-1]};
      q = {q[Q_W-2:0], 1'b0};
      if (t >= {1'b0, n}) begin
        t = t - {1'b0, n};
      end
      r = t[N_W-1:0];
    end
    item_nxt.rem = r;
    item_nxt.q   = q;
  end

  // Take a new request when empty or when the next stage takes ours
  assign up_ready = !valid_r || down_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item_r <= item_nxt;
    end
  end

endmodule : stm_mod_stage

`default_nettype wire

@@ design/stripe_target_mapper_core.sv @@
// Stripe target mapper: position to stripe target index and target ID.
//
// Input channel (in_*): a map request (cmd 1) takes a 63-bit byte position and
// returns target_index = (position >> chunk_size_log2) mod num_targets (clamped
// to one through the table depth) with the target ID stored at that index.
// A load request (cmd 0) writes entry_id into table slot entry_index; no result.
// Output channel (out_*): one result per map request, in request order.
// Configuration (cfg_*): register 0 is chunk_size_log2, register 1 is
// num_targets; write them only while no request is in flight.
// Throughput: one request per cycle while out_stall is low. The pipeline is
// one input stage with the chunk shift, then eight remainder
// stages of eight quotient bits each, and the table read into the output stage.
// Loads write the table at the same pipeline point where maps read it, so
// every map sees exactly the loads accepted before it.
// Reset empties the pipeline and restores the register defaults; table contents
// are undefined until loaded. A stall on out_stall holds the result and lets
// requests close up behind it; in_stall rises only once the pipeline is full.
`default_nettype none

module stripe_target_mapper_core
  import stm_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_cmd,
  input  wire logic [POS_W-1:0]   in_position,
  input  wire logic [EIDX_W-1:0]  in_entry_index,
  input  wire logic [EID_W-1:0]   in_entry_id,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic      [EIDX_W-1:0]  out_target_index,
  output logic      [EID_W-1:0]   out_target_id,
  input  wire logic               cfg_we,
  input  wire logic [0:0]         cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_wdata
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [N_W-1:0] MAX_N = (TABLE_DEPTH > 127) ? 7'd127 : N_W'(TABLE_DEPTH);

  // Configuration registers
  logic [SHIFT_W-1:0] chunk_log2_r;
  logic [N_W-1:0]     num_targets_r;
  logic [N_W-1:0]     eff_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_log2_r  <= SHIFT_W'(16);
      num_targets_r <= N_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CHUNK_LOG2:  chunk_log2_r  <= cfg_wdata[SHIFT_W-1:0];
        CFG_NUM_TARGETS: num_targets_r <= cfg_wdata[N_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the target count to one through the table depth
  always_comb begin
    eff_n = num_targets_r;
    if (eff_n == '0) begin
      eff_n = N_W'(1);
    end
    if (eff_n > MAX_N) begin
      eff_n = MAX_N;
    end
  end

  // Input stage: drop the in-chunk offset bits
  logic      s0_valid_r;
  stm_item_t s0_item_r;
  stm_item_t s0_item_nxt;
  logic      s0_ready;
  logic      mod_ready [MOD_STAGES+1];
  logic      mod_valid [MOD_STAGES+1];
  stm_item_t mod_item  [MOD_STAGES+1];

  always_comb begin
    s0_item_nxt.cmd         = in_cmd;
    s0_item_nxt.q           = {1'b0, in_position} >> chunk_log2_r;
    s0_item_nxt.rem         = '0;
    s0_item_nxt.entry_index = in_entry_index;
    s0_item_nxt.entry_id    = in_entry_id;
  end

  assign s0_ready = !s0_valid_r || mod_ready[0];
  assign in_stall = !s0_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (s0_ready) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_ready && in_valid) begin
      s0_item_r <= s0_item_nxt;
    end
  end

  // Remainder pipeline
  assign mod_valid[0] = s0_valid_r;
  assign mod_item[0]  = s0_item_r;

  for (genvar g = 0; g < MOD_STAGES; g++) begin : g_mod
    stm_mod_stage u_stage (
      .clk        (clk),
      .rst_n      (rst_n),
      .n          (eff_n),
      .up_valid   (mod_valid[g]),
      .up_item    (mod_item[g]),
      .up_ready   (mod_ready[g]),
      .valid_r    (mod_valid[g+1]),
      .item_r     (mod_item[g+1]),
      .down_ready (mod_ready[g+1])
    );
  end

  // Table stage: loads write, maps read into the output register
  stm_item_t                  last_item;
  logic                       last_valid;
  logic                       out_ready;
  logic                       consume;
  logic                       ram_we;
  logic                       ram_re;
  logic [EIDX_W+AW-1:0]       waddr_ext;
  logic [N_W+AW-1:0]          raddr_ext;
  logic                       out_valid_r;
  logic [EIDX_W-1:0]          out_target_index_r;

  assign last_item  = mod_item[MOD_STAGES];
  assign last_valid = mod_valid[MOD_STAGES];
  assign out_ready  = !out_valid_r || !out_stall;
  assign mod_ready[MOD_STAGES] = out_ready || (last_item.cmd == CMD_LOAD);
  assign consume    = last_valid && mod_ready[MOD_STAGES];
  assign ram_we     = consume && (last_item.cmd == CMD_LOAD)
                      && (32'(last_item.entry_index) < 32'(TABLE_DEPTH));
  assign ram_re     = consume && (last_item.cmd == CMD_MAP);
  assign waddr_ext  = {{AW{1'b0}}, last_item.entry_index};
  assign raddr_ext  = {{AW{1'b0}}, last_item.rem};

  stm_ram #(
    .WIDTH (EID_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr_ext[AW-1:0]),
    .wdata (last_item.entry_id),
    .re    (ram_re),
    .raddr (raddr_ext[AW-1:0]),
    .rdata (out_target_id)
  );

  // Output register; hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= ram_re;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      out_target_index_r <= last_item.rem[EIDX_W-1:0];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_target_index = out_target_index_r;

  // Checks
  a_no_rw_same_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("table written and read in the same cycle");

  a_accept_fills_s0: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> s0_valid_r)
    else $error("accepted request missing from input stage");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s0_valid_r && mod_valid[1]))
    else $error("input stalled while pipeline has room");

  a_out_from_map: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ram_re))
    else $error("result without a map request");

endmodule : stripe_target_mapper_core

`default_nettype wire

@@ bench/tb_stripe_target_mapper_core.sv @@
// Testbench for stripe_target_mapper_core: predicts each mapped target and checks the results.
module tb_stripe_target_mapper_core;
  timeunit 1ns;
  timeprecision 1ps;
  import stm_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int QUIET_LIMIT = 4000;
  localparam int FLUSH_CYCLES = 20;
  localparam int HOLD_CYCLES = 300;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // One mapped target as the block reports it
  typedef struct packed {
    logic [EIDX_W-1:0] index;
    logic [EID_W-1:0]  id;
  } target_hit_t;

  // Predict the target of each map request and compare it with what comes out
  class target_map_predictor;
    logic [SHIFT_W-1:0] chunk_log2;
    logic [N_W-1:0]     num_targets;
    logic [EID_W-1:0]   id_table [TABLE_DEPTH];
    target_hit_t        pending_targets [$];
    int                 mismatches;

    function new();
      chunk_log2 = SHIFT_W'(16);
      num_targets = N_W'(1);
      mismatches = 0;
      foreach (id_table[i]) id_table[i] = '0;
    endfunction

    function void set_reg(logic [0:0] index, logic [CFG_W-1:0] value);
      case (index)
        CFG_CHUNK_LOG2:  chunk_log2 = value[SHIFT_W-1:0];
        CFG_NUM_TARGETS: num_targets = value[N_W-1:0];
        default: ;
      endcase
    endfunction

    // Reduce the position to its stripe set, then to the chunk within it
    function target_hit_t lookup(logic [POS_W-1:0] pos);
      logic [N_W-1:0] n;
      logic [63:0]    set_size;
      logic [63:0]    inner;
      logic [63:0]    slot;
      target_hit_t    hit;
      n = num_targets;
      if (n == 0) n = N_W'(1);
      if (n > TABLE_DEPTH) n = N_W'(TABLE_DEPTH);
      set_size = 64'(n) << chunk_log2;
      inner = {1'b0, pos} % set_size;
      slot = inner >> chunk_log2;
      if (slot >= TABLE_DEPTH) slot = 64'(TABLE_DEPTH - 1);
      hit.index = slot[EIDX_W-1:0];
      hit.id = id_table[slot[EIDX_W-1:0]];
      return hit;
    endfunction

    function void note_request(logic cmd, logic [POS_W-1:0] pos,
                               logic [EIDX_W-1:0] eidx, logic [EID_W-1:0] eid);
      if (cmd == CMD_LOAD) begin
        if (eidx < TABLE_DEPTH) id_table[eidx] = eid;
      end else begin
        pending_targets.push_back(lookup(pos));
      end
    endfunction

    function void check_result(logic [EIDX_W-1:0] index, logic [EID_W-1:0] id);
      target_hit_t want;
      if (pending_targets.size() == 0) begin
        mismatches++;
        $display("%0t: result with no request pending: expected none, got index %0d id %h",
                 $time, index, id);
        return;
      end
      want = pending_targets.pop_front();
      if (index !== want.index) begin
        mismatches++;
        $display("%0t: target_index expected %0d, got %0d", $time, want.index, index);
      end
      if (id !== want.id) begin
        mismatches++;
        $display("%0t: target_id expected %h, got %h", $time, want.id, id);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_cmd = CMD_LOAD;
  logic [POS_W-1:0]   in_position = '0;
  logic [EIDX_W-1:0]  in_entry_index = '0;
  logic [EID_W-1:0]   in_entry_id = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [EIDX_W-1:0]  out_target_index;
  logic [EID_W-1:0]   out_target_id;
  logic               cfg_we = 1'b0;
  logic [0:0]         cfg_index = CFG_CHUNK_LOG2;
  logic [CFG_W-1:0]   cfg_wdata = '0;

  logic               hold_go = 1'b0;
  int                 send_idle_pct = 7;
  int                 recv_idle_pct = 83;
  bit                 loaded [TABLE_DEPTH];
  target_map_predictor sb;

  stripe_target_mapper_core #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_position     (in_position),
    .in_entry_index  (in_entry_index),
    .in_entry_id     (in_entry_id),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_target_index(out_target_index),
    .out_target_id   (out_target_id),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Record accepted requests and check accepted results
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      sb.note_request(in_cmd, in_position, in_entry_index, in_entry_id);
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_target_index, out_target_id);
  end

  // Stall the result side at random; hold it off for a long stretch once
  initial begin
    int hold_cnt;
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // End the run when nothing moves for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
        quiet = 0;
      else
        quiet++;
    end
    $display("Mismatches found");
    $finish;
  end

  // Offer one request, idling first at random, and wait for it to be taken
  task automatic send_request(logic cmd, logic [POS_W-1:0] pos,
                              logic [EIDX_W-1:0] eidx, logic [EID_W-1:0] eid);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_position <= pos;
    in_entry_index <= eidx;
    in_entry_id <= eid;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_load(logic [EIDX_W-1:0] eidx, logic [EID_W-1:0] eid);
    loaded[eidx] = 1'b1;
    send_request(CMD_LOAD, POS_W'({$urandom, $urandom}), eidx, eid);
  endtask

  // Load the slot a position lands on first if it was never written
  task automatic send_map(logic [POS_W-1:0] pos);
    target_hit_t hit;
    hit = sb.lookup(pos);
    if (!loaded[hit.index]) send_load(hit.index, EID_W'($urandom));
    send_request(CMD_MAP, pos, EIDX_W'($urandom), EID_W'($urandom));
  endtask

  // Wait for every pending result, then let trailing loads clear the pipeline
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_targets.size() != 0) @(posedge clk);
    repeat (FLUSH_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(logic [SHIFT_W-1:0] chunk, logic [N_W-1:0] targets);
    cfg_we <= 1'b1;
    cfg_index <= CFG_CHUNK_LOG2;
    cfg_wdata <= CFG_W'(chunk);
    @(posedge clk);
    cfg_index <= CFG_NUM_TARGETS;
    cfg_wdata <= CFG_W'(targets);
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(CFG_CHUNK_LOG2, CFG_W'(chunk));
    sb.set_reg(CFG_NUM_TARGETS, CFG_W'(targets));
  endtask

  initial begin
    int                 phase;
    int                 k;
    logic [63:0]        raw;
    logic [SHIFT_W-1:0] chunk;
    logic [N_W-1:0]     targets;
    sb = new();
    foreach (loaded[i]) loaded[i] = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: one target, table extremes, position extremes
    send_load(EIDX_W'(0), 16'hFFFF);
    send_load(EIDX_W'(63), 16'h0000);
    send_map('0);
    send_map(POS_MAX);

    // Zero targets with the largest chunk
    drain();
    set_regs(SHIFT_W'(31), N_W'(0));
    send_map(POS_MAX);
    send_map(POS_W'(64'h7FFF_FFFF));

    // More targets than table slots, byte-sized chunks
    drain();
    set_regs(SHIFT_W'(0), N_W'(127));
    send_map(POS_W'(63));
    send_map(POS_W'(64));
    send_map(POS_MAX);

    // Power-of-two stripe set
    drain();
    set_regs(SHIFT_W'(3), N_W'(4));
    send_map(POS_W'(31));
    send_map(POS_W'(32));
    send_map(POS_MAX);

    // Stripe set that is not a power of two
    drain();
    set_regs(SHIFT_W'(5), N_W'(3));
    send_map(POS_W'(95));
    send_map(POS_W'(96));
    send_map(POS_MAX);

    // Chunk above the usual range, full table
    drain();
    set_regs(SHIFT_W'(26), N_W'(64));
    send_map(POS_MAX);
    send_map(POS_W'(64'd1 << 26));

    // Random phases, each under its own settings
    for (phase = 0; phase < 24; phase++) begin
      drain();
      if (phase == 8) begin
        send_idle_pct = 83;
        recv_idle_pct = 7;
      end
      if (phase == 16) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (phase % 4)
        0: chunk = SHIFT_W'(0);
        1: chunk = SHIFT_W'(31);
        default: chunk = SHIFT_W'($urandom_range(31));
      endcase
      case (phase % 6)
        0: targets = N_W'(0);
        1: targets = N_W'(64);
        2: targets = N_W'(127);
        default: targets = N_W'($urandom_range(1, 63));
      endcase
      set_regs(chunk, targets);
      // Keep offering requests while the result side is held off
      if (phase == 20) hold_go <= 1'b1;
      for (k = 0; k < 42; k++) begin
        if ($urandom_range(3) == 0) begin
          send_load(EIDX_W'($urandom_range(63)), EID_W'($urandom));
        end else begin
          case ($urandom_range(3))
            0: raw = {$urandom, $urandom};
            1: raw = {$urandom, $urandom} & ((64'd1 << (sb.chunk_log2 + 8)) - 64'd1);
            2: raw = $urandom_range(1) ? '1 : 64'($urandom_range(3));
            default: raw = 64'($urandom_range(200)) * (64'd1 << sb.chunk_log2)
                           + 64'($urandom_range(2)) - 64'd1;
          endcase
          send_map(raw[POS_W-1:0]);
        end
      end
    end

    drain();
    if (sb.mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

@@ files.f @@
design/stm_pkg.sv
design/stm_ram.sv
design/stm_mod_stage.sv
design/stripe_target_mapper_core.sv
bench/tb_stripe_target_mapper_core.sv
